// File: design/frt_pkg.sv
`timescale 1ns / 1ps

package frt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_FRAGMENTS = 64;

    localparam int ENTRY_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PTR_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W    = 24;
    localparam int IDX_W    = 16;
    localparam int MAP_W    = 64;
    localparam int CNT_W    = 7;
    localparam int SEL_W    = 6;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic {
        CMD_RECV  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_INDEX    = 3'd2,
        ST_CAPACITY = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [15:0]      message_id;
        logic [7:0]       stream_id;
        logic [IDX_W-1:0] fragment_index;
        logic [IDX_W-1:0] total_fragments;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic             known;
        logic             complete;
        logic [CNT_W-1:0] received_count;
        logic [MAP_W-1:0] missing_map;
    } t_out_item;

    typedef struct packed {
        t_key             key;
        logic [CNT_W-1:0] total;
        logic [MAP_W-1:0] bits;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic                rd_en;
        logic [ENTRY_AW-1:0] rd_addr;
        logic                wr_en;
        logic [ENTRY_AW-1:0] wr_addr;
        t_entry              wr_entry;
    } t_tbl_req;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_tbl_rsp;

    function automatic logic [MAP_W-1:0] below_mask(input logic [CNT_W-1:0] total);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (CNT_W'(i) < total);
        end
        return m;
    endfunction

endpackage

// File: design/frt_in_if.sv
`timescale 1ns / 1ps

interface frt_in_if import frt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/frt_out_if.sv
`timescale 1ns / 1ps

interface frt_out_if import frt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/frt_table.sv
`timescale 1ns / 1ps

module frt_table import frt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_tbl_rsp o_rsp
);

    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_mem [TABLE_ENTRIES];
    logic                     r_rd_valid;
    t_entry                   r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_entry;
        end
        if (i_req.rd_en) begin
            r_rd_valid <= r_valid[i_req.rd_addr];
            r_rd_entry <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.entry = r_rd_entry;

endmodule

// File: design/frt_seq.sv
`timescale 1ns / 1ps

module frt_seq import frt_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    frt_in_if.sink         i_in,
    frt_out_if.source      o_out,
    output t_tbl_req       o_tbl_req,
    input  t_tbl_rsp       i_tbl_rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_item, n_item;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic                r_pend, n_pend;
    logic [ENTRY_AW-1:0] r_cmp_idx, n_cmp_idx;
    logic                r_hit, n_hit;
    logic [ENTRY_AW-1:0] r_hit_idx, n_hit_idx;
    logic                r_free, n_free;
    logic [ENTRY_AW-1:0] r_free_idx, n_free_idx;
    t_entry              r_ent, n_ent;
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    t_key             key;
    logic             in_acc;
    logic             issue;
    logic             match;
    logic [SEL_W-1:0] sel;
    logic [MAP_W-1:0] new_bit;
    logic             idx_bad;
    t_status          dec_status;
    logic             dec_wr;
    logic [ENTRY_AW-1:0] dec_addr;
    t_entry           dec_entry;
    t_out_item        dec_res;

    assign key     = {r_item.message_id, r_item.stream_id};
    assign in_acc  = i_in.valid && i_in.ready;
    assign issue   = (r_state == S_SCAN) && (r_ptr != PTR_W'(TABLE_ENTRIES));
    assign match   = r_pend && i_tbl_rsp.valid && (i_tbl_rsp.entry.key == key);
    assign sel     = r_item.fragment_index[SEL_W-1:0];
    assign new_bit = MAP_W'(1) << sel;
    assign idx_bad = r_item.fragment_index >= r_item.total_fragments;

    always_comb begin
        dec_status = ST_OK;
        dec_wr     = 1'b0;
        dec_addr   = r_hit_idx;
        dec_entry  = r_ent;
        dec_res    = '0;
        if (r_item.cmd == CMD_RECV) begin
            if (r_hit) begin
                if (r_item.total_fragments != IDX_W'(r_ent.total)) begin
                    dec_status = ST_MISMATCH;
                end else if (idx_bad) begin
                    dec_status = ST_INDEX;
                end else if (!r_ent.bits[sel]) begin
                    dec_wr          = 1'b1;
                    dec_entry.bits  = r_ent.bits | new_bit;
                    dec_entry.count = r_ent.count + CNT_W'(1);
                end
            end else if (idx_bad) begin
                dec_status = ST_INDEX;
            end else if (r_item.total_fragments > IDX_W'(MAX_FRAGMENTS)) begin
                dec_status = ST_CAPACITY;
            end else if (!r_free) begin
                dec_status = ST_FULL;
            end else begin
                dec_wr          = 1'b1;
                dec_addr        = r_free_idx;
                dec_entry.key   = key;
                dec_entry.total = r_item.total_fragments[CNT_W-1:0];
                dec_entry.bits  = new_bit;
                dec_entry.count = CNT_W'(1);
            end
        end else if (r_hit) begin
            dec_res.known          = 1'b1;
            dec_res.received_count = r_ent.count;
            dec_res.complete       = (r_ent.count == r_ent.total);
            dec_res.missing_map    = below_mask(r_ent.total) & ~r_ent.bits;
        end
        dec_res.status = dec_status;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_ent       = r_ent;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item  = i_in.data;
                    n_ptr   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_ptr     = r_ptr + PTR_W'(1);
                    n_pend    = 1'b1;
                    n_cmp_idx = r_ptr[ENTRY_AW-1:0];
                end
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_ent     = i_tbl_rsp.entry;
                    n_state   = S_DECIDE;
                end else begin
                    if (r_pend && !i_tbl_rsp.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (!issue && !r_pend) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_res   = dec_res;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_ent      <= n_ent;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign o_tbl_req.rd_en    = issue;
    assign o_tbl_req.rd_addr  = r_ptr[ENTRY_AW-1:0];
    assign o_tbl_req.wr_en    = (r_state == S_DECIDE) && dec_wr;
    assign o_tbl_req.wr_addr  = dec_addr;
    assign o_tbl_req.wr_entry = dec_entry;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN) && (r_ptr == '0))
        else $error("accepted word did not start a table scan");

    a_write_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tbl_req.wr_en |-> (r_hit || r_free))
        else $error("table write without a matching or free entry");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tbl_req.wr_en |-> (r_item.cmd == CMD_RECV))
        else $error("query word modified the table");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(TABLE_ENTRIES))
        else $error("scan pointer ran past the table");

    a_no_read_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> !o_tbl_req.rd_en)
        else $error("table read issued outside the scan");

endmodule

// File: design/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps

// Each input word is a fragment header (receive) or a stream status query, and each word
// yields exactly one result word. The block takes one word at a time and drops ready while
// it works on it. The stream key is compared against one table entry per cycle through a
// single comparator behind the registered table read, the scan stops early on a match, and
// then the decide state decides and updates the entry and the done state loads the output
// register once it is free. A finished result waits in the output register while the next
// word is accepted. Reset clears every entry's valid bit at once, so no clearing pass is
// needed and the block is ready right after reset.

module fragment_reassembly_tracker import frt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frt_in_if.sink    i_in,
    frt_out_if.source o_out
);

    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;

    frt_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_tbl_req (tbl_req),
        .i_tbl_rsp (tbl_rsp)
    );

    frt_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

endmodule
